>>> rtl/keyed_counter_table_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for keyed_counter_table
// Clocked on clk with reset rst_n; empty when SYNTH is defined.
// ---------------------------------------------------------------------------
`ifndef KEYED_COUNTER_TABLE_ASSERT_SVH
`define KEYED_COUNTER_TABLE_ASSERT_SVH

`ifndef SYNTH

// Check a property on every clock edge outside reset.
`define KCT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition never holds outside reset.
`define KCT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define KCT_ASSERT(lbl, prop, msg)
`define KCT_NEVER(lbl, cond, msg)

`endif

`endif

>>> rtl/kct_pkg.sv
// ---------------------------------------------------------------------------
// kct_pkg
// Operation codes, status codes and controller states of the keyed counter
// table.
// ---------------------------------------------------------------------------
package kct_pkg;

    localparam logic [1:0] OP_ADD    = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_QUERY  = 2'd2;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_INVALID  = 3'd1;
    localparam logic [2:0] ST_SHORT    = 3'd2;
    localparam logic [2:0] ST_FULL     = 3'd3;
    localparam logic [2:0] ST_OVERFLOW = 3'd4;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_DRAIN = 4'b0100,
        S_EXEC  = 4'b1000
    } state_t;

endpackage

>>> rtl/keyed_counter_table.sv
// ---------------------------------------------------------------------------
// keyed_counter_table
// Table of key and count pairs with add, remove and query transactions.
// ---------------------------------------------------------------------------
// Usage:
//   Drive operation, item_key and amount and raise start; the transaction is
//   taken at the clock edge where start is high and busy is low. busy stays
//   high until the result is produced.
//   The result (success, status, item_count) is shown for exactly one cycle
//   with done high; the receiver must take it then, it cannot stall.
// Sequence:
//   The controller reads every slot of the key/count memory once, one
//   address per cycle, then passes S_DRAIN and decides and writes back in
//   S_EXEC. busy is already low in the done cycle, so the next transaction
//   can be taken while done is high; none is taken while one is in flight.
//   The single memory port and the slot scan bound the transaction rate.
// Reset:
//   rst_n clears all slot valid bits (every slot free) and the controller.
//   No clearing pass runs; key and count words are only read behind a valid
//   bit. A transaction can be taken in the first cycle after reset.
// ---------------------------------------------------------------------------
module keyed_counter_table #(
    parameter int CAPACITY   = 16,
    parameter int KEY_BITS   = 32,
    parameter int COUNT_BITS = 31
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         operation,
    input  logic [31:0]        item_key,
    input  logic signed [31:0] amount,
    output logic               done,
    output logic               success,
    output logic [2:0]         status,
    output logic [30:0]        item_count
);

    `include "keyed_counter_table_assert.svh"

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = IDX_W + 1;
    localparam int MEM_W = KEY_BITS + COUNT_BITS;
    localparam int SUM_W = ((COUNT_BITS > 31) ? COUNT_BITS : 31) + 1;

    kct_pkg::state_t state_reg, state_next;

    logic [CNT_W-1:0]      scan_cnt_reg, scan_cnt_next;
    logic                  chk_vld_reg, chk_vld_next;
    logic [IDX_W-1:0]      chk_idx_reg, chk_idx_next;
    logic                  hit_reg, hit_next;
    logic [IDX_W-1:0]      hit_idx_reg, hit_idx_next;
    logic [COUNT_BITS-1:0] hit_count_reg, hit_count_next;
    logic                  free_reg, free_next;
    logic [IDX_W-1:0]      free_idx_reg, free_idx_next;
    logic [CAPACITY-1:0]   slot_valid_reg, slot_valid_next;

    logic [1:0]            op_reg, op_next;
    logic [KEY_BITS-1:0]   key_reg, key_next;
    logic signed [31:0]    amount_reg, amount_next;

    logic                  done_reg, done_next;
    logic                  success_reg, success_next;
    logic [2:0]            status_reg, status_next;
    logic [30:0]           count_out_reg, count_out_next;

    // key/count memory, one word per slot
    logic [MEM_W-1:0]      slot_mem [0:CAPACITY-1];
    logic [MEM_W-1:0]      rd_data_reg;
    logic [IDX_W-1:0]      rd_addr;
    logic                  wr_en;
    logic [IDX_W-1:0]      wr_addr;
    logic [MEM_W-1:0]      wr_data;

    logic [KEY_BITS-1:0]   rd_key;
    logic [COUNT_BITS-1:0] rd_count;
    logic [COUNT_BITS-1:0] cur;
    logic [SUM_W-1:0]      cur_ext;
    logic [SUM_W-1:0]      amt_ext;
    logic [SUM_W-1:0]      sum;
    logic [SUM_W-1:0]      diff;
    logic                  key_bad;
    logic                  amt_bad;
    logic                  accept;
    logic [COUNT_BITS-1:0] res_cnt;

    assign accept   = start && (state_reg == kct_pkg::S_IDLE);
    assign busy     = (state_reg != kct_pkg::S_IDLE);
    assign rd_addr  = scan_cnt_reg[IDX_W-1:0];
    assign rd_key   = rd_data_reg[MEM_W-1 -: KEY_BITS];
    assign rd_count = rd_data_reg[COUNT_BITS-1:0];

    assign cur     = hit_reg ? hit_count_reg : '0;
    assign cur_ext = SUM_W'(cur);
    assign amt_ext = SUM_W'(amount_reg[30:0]);
    assign sum     = cur_ext + amt_ext;
    assign diff    = cur_ext - amt_ext;
    assign key_bad = (key_reg == '0);
    assign amt_bad = amount_reg[31] || (amount_reg == 32'sd0);

    always_comb
    begin
        state_next      = state_reg;
        scan_cnt_next   = scan_cnt_reg;
        chk_vld_next    = 1'b0;
        chk_idx_next    = chk_idx_reg;
        hit_next        = hit_reg;
        hit_idx_next    = hit_idx_reg;
        hit_count_next  = hit_count_reg;
        free_next       = free_reg;
        free_idx_next   = free_idx_reg;
        slot_valid_next = slot_valid_reg;
        op_next         = op_reg;
        key_next        = key_reg;
        amount_next     = amount_reg;
        done_next       = 1'b0;
        success_next    = success_reg;
        status_next     = status_reg;
        count_out_next  = count_out_reg;
        wr_en           = 1'b0;
        wr_addr         = hit_idx_reg;
        wr_data         = {key_reg, sum[COUNT_BITS-1:0]};
        res_cnt         = cur;

        // compare stage: memory word of chk_idx_reg is in rd_data_reg
        if (chk_vld_reg)
        begin
            if (slot_valid_reg[chk_idx_reg] && (rd_key == key_reg) && !hit_reg)
            begin
                hit_next       = 1'b1;
                hit_idx_next   = chk_idx_reg;
                hit_count_next = rd_count;
            end
            // remember the lowest free slot
            if (!slot_valid_reg[chk_idx_reg] && !free_reg)
            begin
                free_next     = 1'b1;
                free_idx_next = chk_idx_reg;
            end
        end

        case (state_reg)
            kct_pkg::S_IDLE:
            begin
                if (start)
                begin
                    op_next       = operation;
                    key_next      = KEY_BITS'(item_key);
                    amount_next   = amount;
                    scan_cnt_next = '0;
                    hit_next      = 1'b0;
                    free_next     = 1'b0;
                    state_next    = kct_pkg::S_SCAN;
                end
            end
            kct_pkg::S_SCAN:
            begin
                chk_vld_next  = 1'b1;
                chk_idx_next  = rd_addr;
                scan_cnt_next = scan_cnt_reg + 1'b1;
                if (scan_cnt_reg == CNT_W'(CAPACITY - 1))
                begin
                    state_next = kct_pkg::S_DRAIN;
                end
            end
            kct_pkg::S_DRAIN:
            begin
                state_next = kct_pkg::S_EXEC;
            end
            kct_pkg::S_EXEC:
            begin
                success_next = 1'b0;
                status_next  = kct_pkg::ST_INVALID;
                case (op_reg)
                    kct_pkg::OP_QUERY:
                    begin
                        if (amount_reg[31] || (cur_ext >= amt_ext))
                        begin
                            success_next = 1'b1;
                            status_next  = kct_pkg::ST_OK;
                        end
                        else
                        begin
                            status_next = kct_pkg::ST_SHORT;
                        end
                    end
                    kct_pkg::OP_ADD:
                    begin
                        if (!key_bad && !amt_bad)
                        begin
                            if (|sum[SUM_W-1:COUNT_BITS])
                            begin
                                status_next = kct_pkg::ST_OVERFLOW;
                            end
                            else if (hit_reg || free_reg)
                            begin
                                // new key: cur is zero, so sum is the amount
                                wr_en        = 1'b1;
                                wr_addr      = hit_reg ? hit_idx_reg : free_idx_reg;
                                res_cnt      = sum[COUNT_BITS-1:0];
                                success_next = 1'b1;
                                status_next  = kct_pkg::ST_OK;
                                slot_valid_next[wr_addr] = 1'b1;
                            end
                            else
                            begin
                                status_next = kct_pkg::ST_FULL;
                            end
                        end
                    end
                    kct_pkg::OP_REMOVE:
                    begin
                        if (!key_bad && !amt_bad)
                        begin
                            if (!hit_reg || (cur_ext < amt_ext))
                            begin
                                status_next = kct_pkg::ST_SHORT;
                            end
                            else
                            begin
                                wr_en        = 1'b1;
                                wr_data      = {key_reg, diff[COUNT_BITS-1:0]};
                                res_cnt      = diff[COUNT_BITS-1:0];
                                success_next = 1'b1;
                                status_next  = kct_pkg::ST_OK;
                                // drop the slot once it runs empty
                                if (diff == '0)
                                begin
                                    slot_valid_next[hit_idx_reg] = 1'b0;
                                end
                            end
                        end
                    end
                    default:
                    begin
                        status_next = kct_pkg::ST_INVALID;
                    end
                endcase
                count_out_next = 31'(res_cnt);
                done_next      = 1'b1;
                state_next     = kct_pkg::S_IDLE;
            end
            default:
            begin
                state_next = kct_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= kct_pkg::S_IDLE;
            scan_cnt_reg   <= '0;
            chk_vld_reg    <= 1'b0;
            hit_reg        <= 1'b0;
            free_reg       <= 1'b0;
            slot_valid_reg <= '0;
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            scan_cnt_reg   <= scan_cnt_next;
            chk_vld_reg    <= chk_vld_next;
            hit_reg        <= hit_next;
            free_reg       <= free_next;
            slot_valid_reg <= slot_valid_next;
            done_reg       <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        chk_idx_reg   <= chk_idx_next;
        hit_idx_reg   <= hit_idx_next;
        hit_count_reg <= hit_count_next;
        free_idx_reg  <= free_idx_next;
        op_reg        <= op_next;
        key_reg       <= key_next;
        amount_reg    <= amount_next;
        success_reg   <= success_next;
        status_reg    <= status_next;
        count_out_reg <= count_out_next;
    end

    // Write-back happens in the last busy cycle and the next scan starts after
    // the idle cycle, so reads never overlap a pending write.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= slot_mem[rd_addr];
    end

    assign done       = done_reg;
    assign success    = success_reg;
    assign status     = status_reg;
    assign item_count = count_out_reg;

    `KCT_ASSERT(a_done_after_exec, done |-> $past(state_reg == kct_pkg::S_EXEC), "done without decision cycle")
    `KCT_NEVER(a_done_while_busy, done && busy, "busy still high with result")
    `KCT_ASSERT(a_success_ok, (done && success) |-> (status == kct_pkg::ST_OK), "success with error status")
    `KCT_ASSERT(a_hit_is_valid, ((state_reg == kct_pkg::S_EXEC) && hit_reg) |-> slot_valid_reg[hit_idx_reg], "hit on free slot")
    `KCT_ASSERT(a_accept_scans, accept |=> (state_reg == kct_pkg::S_SCAN), "accepted transaction did not start scan")

endmodule
